// ===== rtl/mcd_pkg.sv =====
// ----------------------------------------------------------------------------
// mcd_pkg
// Shared types and constants of the depth-first maze carver.
// ----------------------------------------------------------------------------
`default_nettype none

package mcd_pkg;

  // Default grid side limit; the top level hands it down as a parameter.
  localparam int MAX_SIDE_DEF = 64;

  localparam int NUM_DIRS = 4;

  // Register map, index into the register list (byte address 4*index).
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  localparam logic [6:0] GRID_RESET = 7'd16;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_STEP  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_DOWN  = 2'd2,
    DIR_LEFT  = 2'd3
  } dir_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] random_pick;
    logic [5:0] cell_col;
    logic [5:0] cell_row;
  } in_item_t;

  typedef struct packed {
    logic       carved;
    logic [5:0] from_col;
    logic [5:0] from_row;
    logic [1:0] direction;
    logic       finished;
    logic [3:0] wall_bits;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/mcd_nbr_unit.sv =====
// ----------------------------------------------------------------------------
// mcd_nbr_unit
// Shared neighbor unit: coordinates of the cell one step away and grid check.
// ----------------------------------------------------------------------------
`default_nettype none

module mcd_nbr_unit #(
  parameter int CW = 6
) (
  input  wire logic [CW-1:0]   cx,
  input  wire logic [CW-1:0]   cy,
  input  wire mcd_pkg::dir_t   dir,
  input  wire logic [CW:0]     grid_w,
  input  wire logic [CW:0]     grid_h,
  output logic                 nb_ok,
  output logic [CW-1:0]        nb_col,
  output logic [CW-1:0]        nb_row
);
  import mcd_pkg::*;

  logic [CW:0] cx_inc;
  logic [CW:0] cy_inc;

  assign cx_inc = {1'b0, cx} + (CW+1)'(1);
  assign cy_inc = {1'b0, cy} + (CW+1)'(1);

  always_comb begin
    nb_col = cx;
    nb_row = cy;
    nb_ok  = 1'b0;
    unique case (dir)
      DIR_UP: begin
        nb_row = cy - CW'(1);
        nb_ok  = (cy != '0);
      end
      DIR_RIGHT: begin
        nb_col = cx_inc[CW-1:0];
        nb_ok  = (cx_inc < grid_w);
      end
      DIR_DOWN: begin
        nb_row = cy_inc[CW-1:0];
        nb_ok  = (cy_inc < grid_h);
      end
      DIR_LEFT: begin
        nb_col = cx - CW'(1);
        nb_ok  = (cx != '0);
      end
      default: begin
        nb_ok = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/mcd_pick.sv =====
// ----------------------------------------------------------------------------
// mcd_pick
// Chooses one open direction: index (random * count) >> 8 among set bits.
// ----------------------------------------------------------------------------
`default_nettype none

module mcd_pick (
  input  wire logic [3:0]     open_mask,
  input  wire logic [7:0]     rnd,
  output logic                any_open,
  output mcd_pkg::dir_t       sel_dir
);
  import mcd_pkg::*;

  logic [2:0] count;
  logic [9:0] prod;
  logic [1:0] pick;
  logic [1:0] seen;
  logic       found;

  always_comb begin
    count = '0;
    for (int i = 0; i < NUM_DIRS; i++) begin
      count = count + 3'(open_mask[i]);
    end
  end

  assign prod     = 10'(rnd) * 10'(count);
  assign pick     = prod[9:8];
  assign any_open = (count != '0);

  // pick-th set bit, lowest direction first
  always_comb begin
    sel_dir = DIR_UP;
    seen    = '0;
    found   = 1'b0;
    for (int i = 0; i < NUM_DIRS; i++) begin
      if (open_mask[i] && !found) begin
        if (seen == pick) begin
          sel_dir = dir_t'(2'(i));
          found   = 1'b1;
        end
        seen = seen + 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/maze_carver_dfs.sv =====
// ----------------------------------------------------------------------------
// maze_carver_dfs
// Recursive-backtracker maze carver over a configurable grid, one action per
// transaction, with a neighbor scan through a cell memory of one read and one write port.
// ----------------------------------------------------------------------------
// Flow: an in-range read goes through S_RDW; nop, empty-stack step and an
//   out-of-range read go straight to S_OUT; in a step each in-grid neighbor
//   costs a read-and-return pair on the memory port, a carve adds the write
//   states S_WRA and S_WRB; start sweeps all 2**(2*clog2(MAX_SIDE)) entries.
// Throughput: one transaction at a time; in_stall is high until the result
//   is queued in the output register.
// Reset: clears control state and runs the same sweep, setting all walls and
//   clearing visited marks; in_stall stays high.
`default_nettype none

module maze_carver_dfs #(
  parameter int MAX_SIDE = mcd_pkg::MAX_SIDE_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input transaction channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire mcd_pkg::in_item_t  in_data,
  // result transaction channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output mcd_pkg::out_item_t      out_data,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import mcd_pkg::*;

  localparam int CW        = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int AW        = 2 * CW;
  localparam int DW        = AW + 1;
  localparam int MEM_DEPTH = 1 << AW;
  localparam int CELLS     = MAX_SIDE * MAX_SIDE;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RDW,
    S_TOPW,
    S_NBR,
    S_NBRW,
    S_PICK,
    S_WRA,
    S_WRB,
    S_OUT
  } state_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [6:0] grid_w_r;
  logic [6:0] grid_h_r;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_w_r <= GRID_RESET;
      grid_h_r <= GRID_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_GRID_WIDTH) begin
        grid_w_r <= pwdata[6:0];
      end else begin
        grid_h_r <= pwdata[6:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_GRID_WIDTH) ? 32'(grid_w_r) : 32'(grid_h_r);

  // Effective size: zero counts as one, anything above MAX_SIDE is capped.
  logic [CW:0] eff_w;
  logic [CW:0] eff_h;

  always_comb begin
    if (grid_w_r == '0) begin
      eff_w = (CW+1)'(1);
    end else if (32'(grid_w_r) > 32'(MAX_SIDE)) begin
      eff_w = (CW+1)'(MAX_SIDE);
    end else begin
      eff_w = (CW+1)'(grid_w_r);
    end
    if (grid_h_r == '0) begin
      eff_h = (CW+1)'(1);
    end else if (32'(grid_h_r) > 32'(MAX_SIDE)) begin
      eff_h = (CW+1)'(MAX_SIDE);
    end else begin
      eff_h = (CW+1)'(grid_h_r);
    end
  end

  // --------------------------------------------------------------------------
  // Memories: cell store {visited, walls[3:0]} and path stack {row, col}
  // --------------------------------------------------------------------------
  logic [4:0]    cmem [MEM_DEPTH];
  logic [AW-1:0] stk  [MEM_DEPTH];

  logic          cm_we;
  logic [AW-1:0] cm_waddr;
  logic [4:0]    cm_wdata;
  logic [AW-1:0] cm_raddr;
  logic [4:0]    cm_rdata_r;

  logic          sk_we;
  logic [AW-1:0] sk_waddr;
  logic [AW-1:0] sk_wdata;
  logic [AW-1:0] sk_raddr;
  logic [AW-1:0] sk_rdata_r;

  always_ff @(posedge clk) begin
    if (cm_we) begin
      cmem[cm_waddr] <= cm_wdata;
    end
    cm_rdata_r <= cmem[cm_raddr];
  end

  always_ff @(posedge clk) begin
    if (sk_we) begin
      stk[sk_waddr] <= sk_wdata;
    end
    sk_rdata_r <= stk[sk_raddr];
  end

  // --------------------------------------------------------------------------
  // Sequencer registers
  // --------------------------------------------------------------------------
  state_t        state_r,     state_nxt;
  in_item_t      item_r,      item_nxt;
  logic [CW-1:0] cx_r,        cx_nxt;
  logic [CW-1:0] cy_r,        cy_nxt;
  dir_t          dir_r,       dir_nxt;
  logic [3:0]    mask_r,      mask_nxt;
  logic [DW-1:0] depth_r,     depth_nxt;
  logic [AW-1:0] clr_r,       clr_nxt;
  logic          start_r,     start_nxt;
  out_item_t     res_r,       res_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r,  out_data_nxt;

  logic [DW-1:0] depth_m1;
  logic          nb_ok;
  logic [CW-1:0] nb_col;
  logic [CW-1:0] nb_row;
  logic          pk_any;
  dir_t          pk_sel;
  logic          rd_in_range;

  assign depth_m1    = depth_r - DW'(1);
  assign rd_in_range = (32'(in_data.cell_col) < 32'(MAX_SIDE)) &&
                       (32'(in_data.cell_row) < 32'(MAX_SIDE));

  // One neighbor unit serves both the scan and the carve writes.
  mcd_nbr_unit #(
    .CW (CW)
  ) u_nbr (
    .cx     (cx_r),
    .cy     (cy_r),
    .dir    (dir_r),
    .grid_w (eff_w),
    .grid_h (eff_h),
    .nb_ok  (nb_ok),
    .nb_col (nb_col),
    .nb_row (nb_row)
  );

  mcd_pick u_pick (
    .open_mask (mask_r),
    .rnd       (item_r.random_pick),
    .any_open  (pk_any),
    .sel_dir   (pk_sel)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    dir_nxt       = dir_r;
    mask_nxt      = mask_r;
    depth_nxt     = depth_r;
    clr_nxt       = clr_r;
    start_nxt     = start_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    cm_we    = 1'b0;
    cm_waddr = '0;
    cm_wdata = '0;
    cm_raddr = {cy_r, cx_r};
    sk_we    = 1'b0;
    sk_waddr = '0;
    sk_wdata = '0;
    sk_raddr = depth_m1[AW-1:0];     // stack top, ready the cycle after accept

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      // Sweep: all walls up, visited cleared; on a start, cell 0 is marked.
      S_CLEAR: begin
        cm_we    = 1'b1;
        cm_waddr = clr_r;
        cm_wdata = {start_r && (clr_r == '0), 4'hF};
        clr_nxt  = clr_r + AW'(1);
        if (clr_r == '1) begin
          if (start_r) begin
            sk_we     = 1'b1;
            sk_waddr  = '0;
            sk_wdata  = '0;
            depth_nxt = DW'(1);
            res_nxt   = '0;
            start_nxt = 1'b0;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          res_nxt  = '0;
          unique case (action_t'(in_data.action))
            ACT_START: begin
              start_nxt = 1'b1;
              clr_nxt   = '0;
              state_nxt = S_CLEAR;
            end
            ACT_STEP: begin
              if (depth_r == '0) begin
                res_nxt.finished = 1'b1;
                state_nxt        = S_OUT;
              end else begin
                state_nxt = S_TOPW;
              end
            end
            ACT_READ: begin
              if (rd_in_range) begin
                cm_raddr  = {CW'(in_data.cell_row), CW'(in_data.cell_col)};
                state_nxt = S_RDW;
              end else begin
                res_nxt.wall_bits = 4'hF;
                res_nxt.finished  = (depth_r == '0);
                state_nxt         = S_OUT;
              end
            end
            ACT_NOP: begin
              res_nxt.finished = (depth_r == '0);
              state_nxt        = S_OUT;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_RDW: begin
        res_nxt.wall_bits = cm_rdata_r[3:0];
        res_nxt.finished  = (depth_r == '0);
        state_nxt         = S_OUT;
      end

      S_TOPW: begin
        {cy_nxt, cx_nxt} = sk_rdata_r;
        dir_nxt          = DIR_UP;
        mask_nxt         = '0;
        state_nxt        = S_NBR;
      end

      // Neighbor scan: one memory read per in-grid neighbor.
      S_NBR: begin
        if (nb_ok) begin
          cm_raddr  = {nb_row, nb_col};
          state_nxt = S_NBRW;
        end else if (dir_r == DIR_LEFT) begin
          state_nxt = S_PICK;
        end else begin
          dir_nxt = dir_t'(2'(dir_r) + 2'd1);
        end
      end

      S_NBRW: begin
        mask_nxt[dir_r] = !cm_rdata_r[4];
        if (dir_r == DIR_LEFT) begin
          state_nxt = S_PICK;
        end else begin
          dir_nxt   = dir_t'(2'(dir_r) + 2'd1);
          state_nxt = S_NBR;
        end
      end

      S_PICK: begin
        res_nxt.from_col = 6'(cx_r);
        res_nxt.from_row = 6'(cy_r);
        if (!pk_any) begin
          // dead end: backtrack
          depth_nxt        = depth_m1;
          res_nxt.finished = (depth_m1 == '0);
          state_nxt        = S_OUT;
        end else begin
          dir_nxt   = pk_sel;
          cm_raddr  = {cy_r, cx_r};
          state_nxt = S_WRA;
        end
      end

      // Knock down the wall on the current cell, fetch the new cell.
      S_WRA: begin
        cm_we     = 1'b1;
        cm_waddr  = {cy_r, cx_r};
        cm_wdata  = {cm_rdata_r[4], cm_rdata_r[3:0] & ~(4'b0001 << dir_r)};
        cm_raddr  = {nb_row, nb_col};
        state_nxt = S_WRB;
      end

      // Mark the new cell, open its facing wall, push it.
      S_WRB: begin
        cm_we    = 1'b1;
        cm_waddr = {nb_row, nb_col};
        cm_wdata = {1'b1, cm_rdata_r[3:0] & ~(4'b0001 << (2'(dir_r) + 2'd2))};
        if (depth_r < DW'(CELLS)) begin
          sk_we     = 1'b1;
          sk_waddr  = depth_r[AW-1:0];
          sk_wdata  = {nb_row, nb_col};
          depth_nxt = depth_r + DW'(1);
        end
        res_nxt.carved    = 1'b1;
        res_nxt.direction = 2'(dir_r);
        res_nxt.finished  = 1'b0;
        state_nxt         = S_OUT;
      end

      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      start_r     <= 1'b0;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
      dir_r       <= DIR_UP;
      mask_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      start_r     <= start_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= out_valid_nxt;
      dir_r       <= dir_nxt;
      mask_r      <= mask_nxt;
    end
    item_r     <= item_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DW'(CELLS))
    else $error("stack depth above cell count");

  a_carve_push: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRB) |=> (depth_r == DW'($past(depth_r) + DW'(1))))
    else $error("carve did not push exactly one cell");

  a_dead_end_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PICK && !pk_any) |=> (depth_r == DW'($past(depth_r) - DW'(1))))
    else $error("backtrack did not pop exactly one cell");

  a_carved_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.carved) |-> !out_data.finished)
    else $error("carved result flagged finished");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression for the depth-first maze carver. A transaction-level
// predictor of the carver tracks visited marks, walls and the path stack;
// every result transaction is checked field by field against it while the
// sender bursts and the receiver stalls at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mcd_pkg::*;

  localparam int SIDE           = MAX_SIDE_DEF;
  localparam int CELLS          = SIDE * SIDE;
  localparam int ITEM_TARGET    = 1150;
  // A start sweeps the whole cell memory, so the watchdog has to sit well
  // above that sweep plus the longest receiver stall.
  localparam int WATCHDOG_LIMIT = 16000;
  // Longest single transaction besides start/reset is a carving step.
  localparam int DRAIN_CYCLES   = 40;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  initial begin
    forever #6 clk = ~clk;
  end

  maze_carver_dfs dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // --------------------------------------------------------------------------
  // Maze predictor state: our own copy of the carver's memories and registers
  // --------------------------------------------------------------------------
  bit          visited_m [CELLS];
  logic [3:0]  wall_m    [CELLS];
  int          stack_m   [CELLS];
  int          depth_m   = 0;
  logic [6:0]  width_reg = GRID_RESET;
  logic [6:0]  height_reg = GRID_RESET;

  initial begin
    for (int i = 0; i < CELLS; i++) begin
      visited_m[i] = 1'b0;
      wall_m[i]    = 4'hF;
      stack_m[i]   = 0;
    end
  end

  // Register value 0 behaves as 1, anything above the side limit as the limit.
  function automatic int eff_side(input logic [6:0] v);
    if (v == 7'd0) return 1;
    if (int'(v) > SIDE) return SIDE;
    return int'(v);
  endfunction

  // Applies one transaction to the maze state and returns the result it must
  // produce.
  function automatic out_item_t maze_predict(input in_item_t it);
    out_item_t res;
    int        w, h, top, cx, cy, count, pick, nidx;
    dir_t      cand [4];
    dir_t      d;
    res = '0;
    w   = eff_side(width_reg);
    h   = eff_side(height_reg);
    case (action_t'(it.action))
      ACT_START: begin
        for (int i = 0; i < CELLS; i++) begin
          visited_m[i] = 1'b0;
          wall_m[i]    = 4'hF;
        end
        visited_m[0] = 1'b1;
        stack_m[0]   = 0;
        depth_m      = 1;
      end
      ACT_STEP: begin
        if (depth_m == 0) begin
          // nothing to carve: empty stack reports done, state untouched
          res.finished = 1'b1;
        end else begin
          top = stack_m[(depth_m - 1) % CELLS] % CELLS;
          cx  = top % SIDE;
          cy  = top / SIDE;
          res.from_col = 6'(cx);
          res.from_row = 6'(cy);
          // neighbours checked against the size in force right now
          count = 0;
          if (cy > 0 && !visited_m[top - SIDE]) begin
            cand[count] = DIR_UP;
            count++;
          end
          if (cx + 1 < w && cx + 1 < SIDE && !visited_m[top + 1]) begin
            cand[count] = DIR_RIGHT;
            count++;
          end
          if (cy + 1 < h && cy + 1 < SIDE && !visited_m[top + SIDE]) begin
            cand[count] = DIR_DOWN;
            count++;
          end
          if (cx > 0 && !visited_m[top - 1]) begin
            cand[count] = DIR_LEFT;
            count++;
          end
          if (count == 0) begin
            depth_m--;
            res.finished = (depth_m == 0);
          end else begin
            pick = (int'(it.random_pick) * count) >> 8;
            d    = cand[pick];
            case (d)
              DIR_UP:    nidx = top - SIDE;
              DIR_RIGHT: nidx = top + 1;
              DIR_DOWN:  nidx = top + SIDE;
              default:   nidx = top - 1;
            endcase
            visited_m[nidx] = 1'b1;
            wall_m[top][int'(d)] = 1'b0;
            wall_m[nidx][(int'(d) + 2) % 4] = 1'b0;
            if (depth_m < CELLS) begin
              stack_m[depth_m] = nidx;
              depth_m++;
            end
            res.carved    = 1'b1;
            res.direction = d;
          end
        end
      end
      ACT_READ: begin
        res.wall_bits = wall_m[int'(it.cell_row) * SIDE + int'(it.cell_col)];
        res.finished  = (depth_m == 0);
      end
      default: res.finished = (depth_m == 0);
    endcase
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Bookkeeping
  // --------------------------------------------------------------------------
  in_item_t  action_q [$];    // transactions waiting for the driver
  out_item_t outcome_q [$];   // predicted results, oldest first
  int        queued_cnt = 0;
  int        accepted_cnt = 0;
  int        error_count = 0;
  int        idle_cycles = 0;
  logic      in_taken = 1'b0;

  task automatic report_mismatch(input string what);
    error_count++;
    $display("ERROR at %0t ns: %s", $time, what);
  endtask

  // --------------------------------------------------------------------------
  // Driver: bursts of transactions with random gaps; holds the payload while
  // stalled, advances the cycle after an accept.
  // --------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin
    if (in_valid && !in_taken) begin
      // stalled: keep valid and payload as they are
    end else if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (action_q.size() != 0) begin
      in_data  <= action_q.pop_front();
      in_valid <= 1'b1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 10);
        // a third of the bursts run back to back with no gap at all
        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 14);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver stall: switches between several patterns every so often
  // --------------------------------------------------------------------------
  int stall_mode = 0;
  int mode_left = 0;
  int stall_tick = 0;

  always @(negedge clk) begin
    stall_tick <= stall_tick + 1;
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(16, 160);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;                          // free flowing
      1:       out_stall <= ($urandom_range(0, 2) == 0);   // light back-pressure
      2:       out_stall <= ($urandom_range(0, 3) != 0);   // heavy back-pressure
      default: out_stall <= ((stall_tick % 5) < 2);        // fixed rhythm
    endcase
  end

  // --------------------------------------------------------------------------
  // Monitor: predicts on every input accept, checks every output accept
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    out_item_t want;
    logic      in_fire;
    logic      out_fire;
    in_fire  = rst_n && in_valid && !in_stall;
    out_fire = rst_n && out_valid && !out_stall;
    in_taken <= in_fire;
    if (in_fire) begin
      outcome_q.insert(outcome_q.size(), maze_predict(in_data));
      accepted_cnt++;
    end
    if (out_fire) begin
      if (outcome_q.size() == 0) begin
        report_mismatch("result transaction with nothing outstanding");
      end else begin
        want = outcome_q.pop_front();
        if (out_data.carved !== want.carved)
          report_mismatch($sformatf("carved got %0d want %0d",
                                    out_data.carved, want.carved));
        if (out_data.from_col !== want.from_col)
          report_mismatch($sformatf("from_col got %0d want %0d",
                                    out_data.from_col, want.from_col));
        if (out_data.from_row !== want.from_row)
          report_mismatch($sformatf("from_row got %0d want %0d",
                                    out_data.from_row, want.from_row));
        if (out_data.direction !== want.direction)
          report_mismatch($sformatf("direction got %0d want %0d",
                                    out_data.direction, want.direction));
        if (out_data.finished !== want.finished)
          report_mismatch($sformatf("finished got %0d want %0d",
                                    out_data.finished, want.finished));
        if (out_data.wall_bits !== want.wall_bits)
          report_mismatch($sformatf("wall_bits got %h want %h",
                                    out_data.wall_bits, want.wall_bits));
      end
    end
    idle_cycles = (in_fire || out_fire) ? 0 : idle_cycles + 1;
  end

  // Watchdog: a long run with no transaction on either channel is a hang.
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    report_mismatch($sformatf("watchdog expired after %0d idle cycles",
                              WATCHDOG_LIMIT));
    $display("maze_carver_dfs regression: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  int cur_w = 16;   // effective grid size, for aiming reads
  int cur_h = 16;
  int corridor_runs = 0;

  task automatic queue_item(input action_t act, input logic [7:0] pick,
                            input logic [5:0] col, input logic [5:0] row);
    in_item_t it;
    it.action      = act;
    it.random_pick = pick;
    it.cell_col    = col;
    it.cell_row    = row;
    action_q.insert(action_q.size(), it);
    queued_cnt++;
  endtask

  function automatic logic [7:0] rand_pick();
    if ($urandom_range(0, 7) == 0) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly tiny grids, now and then zero or a mid-size one.
  function automatic logic [6:0] rand_side();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 7'd0;
    if (r == 1) return 7'd1;
    if (r < 4)  return 7'($urandom_range(9, 20));
    return 7'($urandom_range(1, 6));
  endfunction

  // Reads land inside the grid most of the time, anywhere in the store else.
  task automatic queue_read();
    logic [5:0] c;
    logic [5:0] r;
    if ($urandom_range(0, 3) == 0) begin
      c = 6'($urandom_range(0, 63));
      r = 6'($urandom_range(0, 63));
    end else begin
      c = 6'($urandom_range(0, cur_w - 1));
      r = 6'($urandom_range(0, cur_h - 1));
    end
    queue_item(ACT_READ, 8'($urandom_range(0, 255)), c, r);
  endtask

  // Carving steps with reads sprinkled in; optionally a stray restart or nop.
  task automatic queue_steps(input int n, input int max_pick, input bit noisy);
    repeat (n) begin
      if ($urandom_range(0, 5) == 0) queue_read();
      if (noisy && $urandom_range(0, 39) == 0)
        queue_item(ACT_NOP, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                   6'($urandom_range(0, 63)));
      if (noisy && $urandom_range(0, 59) == 0)
        queue_item(ACT_START, rand_pick(), 6'($urandom_range(0, 63)),
                   6'($urandom_range(0, 63)));
      queue_item(ACT_STEP, (max_pick == 255) ? rand_pick() : 8'($urandom_range(0, max_pick)),
                 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
    end
  endtask

  // Block until every queued transaction went in and every result came out,
  // then leave a little slack so the carver is truly idle.
  task automatic settle();
    while (accepted_cnt != queued_cnt || outcome_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic apb_write(input logic idx, input logic [6:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= {25'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_GRID_WIDTH) width_reg = val;
    else height_reg = val;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_grid(input logic [6:0] w, input logic [6:0] h);
    settle();
    apb_write(REG_GRID_WIDTH, w);
    apb_write(REG_GRID_HEIGHT, h);
    cur_w = eff_side(w);
    cur_h = eff_side(h);
    @(posedge clk);
  endtask

  // Full carve of a small grid most of the time, or a partial carve otherwise.
  task automatic fresh_maze();
    int full;
    int n;
    set_grid(rand_side(), rand_side());
    queue_item(ACT_START, rand_pick(), 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
    full = 2 * cur_w * cur_h - 1;
    if (cur_w * cur_h <= 24 && $urandom_range(0, 3) != 0) n = full + $urandom_range(0, 2);
    else n = $urandom_range(10, 50);
    queue_steps(n, 255, 1'b1);
    repeat ($urandom_range(2, 8)) queue_read();
  endtask

  // Grid resized between phases while a carve may still be underway, so the
  // stack top can sit outside the new grid.
  task automatic resize_midway();
    set_grid(rand_side(), rand_side());
    queue_steps($urandom_range(5, 30), 255, 1'b1);
    repeat ($urandom_range(1, 4)) queue_read();
  endtask

  // Walk along the top row to column 63, then raise the grid height and walk down the
  // right edge to row 63: exercises the full-size grid and oversize registers.
  task automatic corridor_walk();
    corridor_runs++;
    set_grid(($urandom_range(0, 1) != 0) ? 7'd64 : 7'd127, 7'd1);
    queue_item(ACT_START, rand_pick(), 6'd0, 6'd0);
    queue_steps(63, 255, 1'b0);
    set_grid(width_reg, 7'($urandom_range(64, 127)));
    // two candidates (down, left); picks below 128 take down
    queue_steps(63, 127, 1'b0);
    queue_item(ACT_READ, 8'h00, 6'd63, 6'd63);
    queue_item(ACT_READ, 8'hFF, 6'd63, 6'd0);
    queue_item(ACT_READ, 8'h5A, 6'd62, 6'd63);
    queue_item(ACT_READ, 8'hA5, 6'd0, 6'd0);
    queue_steps($urandom_range(3, 10), 255, 1'b0);
  endtask

  // Unstructured transactions of every action with random fields.
  task automatic noise_burst();
    repeat ($urandom_range(5, 20)) begin
      queue_item(action_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int kind;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Before any start: stack empty, every wall still up.
    queue_item(ACT_NOP, 8'hFF, 6'h3F, 6'h3F);
    queue_item(ACT_STEP, 8'h00, 6'h00, 6'h00);
    queue_item(ACT_READ, 8'hFF, 6'h00, 6'h00);
    queue_item(ACT_READ, 8'h00, 6'h3F, 6'h3F);

    // 2x2 grid carved to completion, then one step past the end.
    set_grid(7'd2, 7'd2);
    queue_item(ACT_START, 8'h00, 6'h3F, 6'h00);
    queue_item(ACT_STEP, 8'hFF, 6'h00, 6'h3F);
    queue_item(ACT_STEP, 8'h00, 6'h15, 6'h2A);
    queue_item(ACT_STEP, 8'h80, 6'h2A, 6'h15);
    queue_item(ACT_STEP, 8'h7F, 6'h00, 6'h00);
    queue_item(ACT_STEP, 8'h01, 6'h3F, 6'h3F);
    queue_item(ACT_STEP, 8'hFE, 6'h00, 6'h00);
    queue_item(ACT_STEP, 8'h40, 6'h00, 6'h00);
    queue_item(ACT_STEP, 8'hC0, 6'h00, 6'h00);
    queue_item(ACT_READ, 8'h00, 6'd0, 6'd0);
    queue_item(ACT_READ, 8'h00, 6'd1, 6'd0);
    queue_item(ACT_READ, 8'h00, 6'd0, 6'd1);
    queue_item(ACT_READ, 8'h00, 6'd1, 6'd1);
    queue_item(ACT_NOP, 8'h00, 6'h00, 6'h00);

    // Zero-size registers behave as a single cell: one pop and done.
    set_grid(7'd0, 7'd0);
    queue_item(ACT_START, 8'hFF, 6'h3F, 6'h3F);
    queue_item(ACT_STEP, 8'hFF, 6'h3F, 6'h3F);
    queue_item(ACT_STEP, 8'h00, 6'h00, 6'h00);
    queue_item(ACT_READ, 8'h00, 6'd0, 6'd0);

    // Random phases until enough transactions have been queued.
    while (queued_cnt < ITEM_TARGET) begin
      kind = $urandom_range(0, 19);
      if (kind < 12) fresh_maze();
      else if (kind < 15) resize_midway();
      else if (kind < 17 && corridor_runs < 2) corridor_walk();
      else noise_burst();
    end

    // Drain, then give any stray result time to show up.
    while (accepted_cnt != queued_cnt || outcome_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (outcome_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", outcome_q.size()));

    if (error_count == 0) begin
      $display("maze_carver_dfs regression: pass");
    end else begin
      $display("maze_carver_dfs regression: fail");
    end
    $finish;
  end

endmodule
